@@ hdl/tkns_pkg.sv @@
// Shared types and constants for the top-k nearest selector.
// No dependencies; used by tkns_cell and top_k_nearest_selector.
`timescale 1ns / 1ps

package tkns_pkg;

  localparam int K_MAX_DEF   = 32;  // cells in the sorted chain
  localparam int ID_BITS_DEF = 32;  // width of the candidate id counter
  localparam int DIST_W      = 32;  // signed Q16.16 distance
  localparam int OUT_ID_W    = 32;  // reported id width
  localparam int K_W         = 6;   // k_count register width
  localparam logic [K_W-1:0] K_RESET = 6'd10;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;    // insert the new candidate into the sorted chain
    logic drain;  // shift the chain one place toward cell 0
  } ctl_t;

endpackage

@@ hdl/tkns_cell.sv @@
// One cell of the sorted insertion chain: holds one kept (distance, id) pair.
// Depends on tkns_pkg.
`timescale 1ns / 1ps

module tkns_cell #(
  parameter int ID_BITS = tkns_pkg::ID_BITS_DEF,
  parameter int FILL_W  = 6,
  parameter int INDEX   = 0
) (
  input  logic                        clk,
  input  tkns_pkg::ctl_t              ctl,
  input  logic [FILL_W-1:0]           fill,
  input  logic [tkns_pkg::DIST_W-1:0] new_dist,
  input  logic [ID_BITS-1:0]          new_id,
  input  logic [tkns_pkg::DIST_W-1:0] left_dist,
  input  logic [ID_BITS-1:0]          left_id,
  input  logic                        left_ins,
  input  logic [tkns_pkg::DIST_W-1:0] right_dist,
  input  logic [ID_BITS-1:0]          right_id,
  output logic [tkns_pkg::DIST_W-1:0] held_dist,
  output logic [ID_BITS-1:0]          id,
  output logic                        ins_here
);

  logic occupied;
  logic keep_ahead;

  assign occupied = int'(fill) > INDEX;

  // order is (distance, then id), smaller first
  always_comb begin
    if (held_dist != new_dist) begin
      keep_ahead = $signed(held_dist) < $signed(new_dist);
    end else begin
      keep_ahead = id < new_id;
    end
  end

  // candidate lands here or further left; chain is sorted so this is a suffix
  assign ins_here = !(occupied && keep_ahead);

  always_ff @(posedge clk) begin
    if (ctl.drain) begin
      held_dist <= right_dist;
      id        <= right_id;
    end else if (ctl.ins && ins_here) begin
      if (left_ins) begin
        held_dist <= left_dist;
        id        <= left_id;
      end else begin
        held_dist <= new_dist;
        id        <= new_id;
      end
    end
  end

endmodule

@@ hdl/top_k_nearest_selector.sv @@
// Top level of the top-k nearest selector: chain of tkns_cell, run control,
// output register. Depends on tkns_pkg and tkns_cell.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  in       | in_valid / in_stall   | distance, last_candidate
//  out      | out_valid / out_stall | neighbor_id, neighbor_distance, status, last
//  config   | cfg_write_en          | cfg_write_data (k_count)
//
// A candidate is taken every cycle while in_stall is low; insertion into the chain is registered.
// After the last candidate of a run, in_stall stays high while k results leave
// cell 0 one per cycle, paused by out_stall; an invalid run gives one error result.
// rst is synchronous: empty list, id 0, k_count 10, no result pending.
// The output register holds its transaction while out_stall is high.
`timescale 1ns / 1ps

module top_k_nearest_selector #(
  parameter int K_MAX   = tkns_pkg::K_MAX_DEF,
  parameter int ID_BITS = tkns_pkg::ID_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tkns_pkg::DIST_W-1:0]   distance,
  input  logic                          last_candidate,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tkns_pkg::OUT_ID_W-1:0] neighbor_id,
  output logic [tkns_pkg::DIST_W-1:0]   neighbor_distance,
  output logic                          status,
  output logic                          last,
  input  logic                          cfg_write_en,
  input  logic [tkns_pkg::K_W-1:0]      cfg_write_data
);

  localparam int FW = $clog2(K_MAX + 1);

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_ERR   = 2'd2;

  logic [1:0]                 state;
  logic [tkns_pkg::K_W-1:0]   k_count;
  logic [tkns_pkg::K_W-1:0]   remain;
  logic [FW-1:0]              fill_count;
  logic [ID_BITS-1:0]         cand_idx;
  logic                       ids_exhausted;
  logic                       id_overflow;

  logic [FW-1:0]              cap;
  logic [FW-1:0]              fill_eff;
  logic [FW-1:0]              fill_new;
  logic                       in_acc;
  logic                       out_free;
  logic                       run_bad;
  tkns_pkg::ctl_t             ctl;

  logic [tkns_pkg::DIST_W-1:0] cell_dist [K_MAX];
  logic [ID_BITS-1:0]          cell_id   [K_MAX];
  logic [K_MAX-1:0]            cell_ins;

  assign in_stall = (state != ST_RUN);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    if (k_count != '0 && int'(k_count) <= K_MAX) begin
      cap = FW'(k_count);
    end else begin
      cap = '0;
    end
  end

  // list is cut to the current k before each candidate
  assign fill_eff = (fill_count > cap) ? cap : fill_count;
  assign fill_new = (!ids_exhausted && fill_eff < cap) ? fill_eff + FW'(1) : fill_eff;

  assign run_bad = (cap == '0) || id_overflow || ids_exhausted ||
                   (int'(fill_new) < int'(k_count));

  assign ctl.ins   = in_acc && !ids_exhausted;
  assign ctl.drain = (state == ST_DRAIN) && out_free;

  for (genvar g = 0; g < K_MAX; g++) begin : g_cell
    logic [tkns_pkg::DIST_W-1:0] l_dist;
    logic [ID_BITS-1:0]          l_id;
    logic                        l_ins;
    logic [tkns_pkg::DIST_W-1:0] r_dist;
    logic [ID_BITS-1:0]          r_id;

    if (g == 0) begin : g_head
      assign l_dist = '0;
      assign l_id   = '0;
      assign l_ins  = 1'b0;
    end else begin : g_mid
      assign l_dist = cell_dist[g-1];
      assign l_id   = cell_id[g-1];
      assign l_ins  = cell_ins[g-1];
    end

    if (g == K_MAX - 1) begin : g_tail
      assign r_dist = '0;
      assign r_id   = '0;
    end else begin : g_body
      assign r_dist = cell_dist[g+1];
      assign r_id   = cell_id[g+1];
    end

    tkns_cell #(
      .ID_BITS (ID_BITS),
      .FILL_W  (FW),
      .INDEX   (g)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .fill       (fill_eff),
      .new_dist   (distance),
      .new_id     (cand_idx),
      .left_dist  (l_dist),
      .left_id    (l_id),
      .left_ins   (l_ins),
      .right_dist (r_dist),
      .right_id   (r_id),
      .held_dist  (cell_dist[g]),
      .id         (cell_id[g]),
      .ins_here   (cell_ins[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_count <= tkns_pkg::K_RESET;
    end else if (cfg_write_en) begin
      k_count <= cfg_write_data;
    end
  end

  // run control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_RUN;
      remain        <= '0;
      fill_count    <= '0;
      cand_idx      <= '0;
      ids_exhausted <= 1'b0;
      id_overflow   <= 1'b0;
    end else begin
      case (state)
        ST_RUN: begin
          if (in_acc) begin
            if (last_candidate) begin
              fill_count    <= '0;
              cand_idx      <= '0;
              ids_exhausted <= 1'b0;
              id_overflow   <= 1'b0;
              remain        <= k_count;
              state         <= run_bad ? ST_ERR : ST_DRAIN;
            end else begin
              fill_count <= fill_new;
              if (ids_exhausted) begin
                id_overflow <= 1'b1;
              end else if (cand_idx == '1) begin
                ids_exhausted <= 1'b1;
              end else begin
                cand_idx <= cand_idx + ID_BITS'(1);
              end
            end
          end
        end
        ST_DRAIN: begin
          if (out_free) begin
            remain <= remain - tkns_pkg::K_W'(1);
            if (remain == tkns_pkg::K_W'(1)) begin
              state <= ST_RUN;
            end
          end
        end
        ST_ERR: begin
          if (out_free) begin
            state <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DRAIN && out_free) begin
      out_valid <= 1'b1;
    end else if (state == ST_ERR && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DRAIN && out_free) begin
      neighbor_id       <= tkns_pkg::OUT_ID_W'(cell_id[0]);
      neighbor_distance <= cell_dist[0];
      status            <= 1'b0;
      last              <= (remain == tkns_pkg::K_W'(1));
    end else if (state == ST_ERR && out_free) begin
      neighbor_id       <= '0;
      neighbor_distance <= '0;
      status            <= 1'b1;
      last              <= 1'b1;
    end
  end

  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> last)
    else $error("invalid status result without last");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> fill_count == '0 && remain != '0)
    else $error("drain with a live run or no results left");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    int'(fill_count) <= K_MAX)
    else $error("fill count beyond chain length");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    in_acc && last_candidate |=> state != ST_RUN)
    else $error("last candidate did not start result delivery");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(neighbor_id) && $stable(last))
    else $error("stalled result changed");

endmodule
